@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the mirrored byte RAM.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BEMR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BEMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bemr_pkg.sv @@
// Package of the mirrored byte RAM: widths, codes and reset values.
// Used by every module of the block; depends on nothing.
package bemr_pkg;

	localparam int STORE_ADDR_BITS_DEF = 16;

	localparam int ADDR_W = 64;
	localparam int BASE_W = 32;
	localparam int DATA_W = 64;
	localparam int HALF_W = 32;
	localparam int ROW_W  = 64;
	localparam int WIN_W  = 2 * ROW_W;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] SIZE_8 = 2'd3;

	localparam logic [1:0] STATUS_DONE = 2'd0;
	localparam logic [1:0] STATUS_REJ  = 2'd1;
	localparam logic [1:0] STATUS_HALF = 2'd2;

	localparam logic CFG_DIRECT = 1'b0;
	localparam logic CFG_MIRROR = 1'b1;

	localparam logic [BASE_W-1:0] DIRECT_BASE_RST = 32'h0000_0000;
	localparam logic [BASE_W-1:0] MIRROR_BASE_RST = 32'h8000_0000;

endpackage

@@ rtl/bemr_bank.sv @@
// One bank of 8-byte rows of the store; one write port, one registered read port.
// Depends on bemr_pkg.
module bemr_bank #(
	parameter int IDX_BITS = bemr_pkg::STORE_ADDR_BITS_DEF - 4
) (
	input  logic                       clk,
	input  logic                       re,
	input  logic [IDX_BITS-1:0]        ridx,
	output logic [bemr_pkg::ROW_W-1:0] rdata,
	input  logic                       we,
	input  logic [IDX_BITS-1:0]        widx,
	input  logic [bemr_pkg::ROW_W-1:0] wdata
);

	logic [bemr_pkg::ROW_W-1:0] mem [0:(1 << IDX_BITS)-1];
	logic [bemr_pkg::ROW_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[widx] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[ridx];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/bemr_locate.sv @@
// Address check and window decode for one access part of up to four bytes.
// Depends on bemr_pkg.
module bemr_locate #(
	parameter int STORE_ADDR_BITS = bemr_pkg::STORE_ADDR_BITS_DEF
) (
	input  logic [bemr_pkg::ADDR_W-1:0] address,
	input  logic                        part,
	input  logic [2:0]                  nbytes,
	input  logic [bemr_pkg::BASE_W-1:0] direct_base,
	input  logic [bemr_pkg::BASE_W-1:0] mirror_base,
	output logic                        ok,
	output logic [STORE_ADDR_BITS-1:0]  off
);

	localparam int A = STORE_ADDR_BITS;
	localparam logic [A:0] WIN_BYTES = {1'b1, {A{1'b0}}};
	localparam logic [32:0] ADDR_TOP = 33'h0_FFFF_FFFF;

	logic        hi_bad;
	logic [32:0] a33;
	logic [32:0] lim;
	logic        range_bad;
	logic [31:0] a32;
	logic        d_borrow;
	logic [31:0] d_rel;
	logic        m_borrow;
	logic [31:0] m_rel;
	logic        in_d;
	logic        in_m;
	logic        d_over;
	logic        m_over;

	always_comb begin
		hi_bad    = |address[63:32];
		// second half of an eight-byte access starts four bytes on
		a33       = {1'b0, address[31:0]} + (part ? 33'd4 : 33'd0);
		lim       = ADDR_TOP - {30'b0, nbytes};
		range_bad = a33 > lim;
		a32       = a33[31:0];

		{d_borrow, d_rel} = {1'b0, a32} - {1'b0, direct_base};
		{m_borrow, m_rel} = {1'b0, a32} - {1'b0, mirror_base};
		in_d = !d_borrow && (d_rel[31:A] == '0);
		in_m = !m_borrow && (m_rel[31:A] == '0);
		d_over = ({1'b0, d_rel[A-1:0]} + {{(A-2){1'b0}}, nbytes}) > WIN_BYTES;
		m_over = ({1'b0, m_rel[A-1:0]} + {{(A-2){1'b0}}, nbytes}) > WIN_BYTES;

		// first byte picks the window, direct first; an overrun never falls through
		if (hi_bad || range_bad) begin
			ok = 1'b0;
		end else if (in_d) begin
			ok = !d_over;
		end else begin
			ok = in_m && !m_over;
		end
		off = in_d ? d_rel[A-1:0] : m_rel[A-1:0];
	end

endmodule

@@ rtl/bemr_lane.sv @@
// Byte lanes over a two-row window: big-endian extract and insert of 1..4 bytes.
// Depends on bemr_pkg.
module bemr_lane (
	input  logic [bemr_pkg::WIN_W-1:0]  window,
	input  logic [2:0]                  byte_off,
	input  logic [2:0]                  nbytes,
	input  logic [bemr_pkg::HALF_W-1:0] wval,
	output logic [bemr_pkg::HALF_W-1:0] rval,
	output logic [bemr_pkg::WIN_W-1:0]  wnew
);

	always_comb begin
		int k;
		wnew = window;
		for (int j = 0; j < 16; j++) begin
			k = j - int'(byte_off);
			if (k >= 0 && k < int'(nbytes)) begin
				wnew[bemr_pkg::WIN_W-1-8*j -: 8] = wval[8*(int'(nbytes)-1-k) +: 8];
			end
		end
	end

	always_comb begin
		rval = '0;
		for (int k = 0; k < 4; k++) begin
			if (k < int'(nbytes)) begin
				rval[8*(int'(nbytes)-1-k) +: 8] =
					window[bemr_pkg::WIN_W-1-8*(int'(byte_off)+k) -: 8];
			end
		end
	end

endmodule

@@ rtl/big_endian_mirrored_ram_top.sv @@
// Top level of the mirrored byte RAM: sequencer, configuration, result register.
// Depends on bemr_pkg, bemr_bank, bemr_locate, bemr_lane and assert_macros.svh.
//
// Byte-addressed RAM of 2^STORE_ADDR_BITS bytes seen through a direct and a
// mirror window whose bases are set through the configuration port (write
// them only while the block is idle). Reads and writes of 1, 2 or 4 bytes
// pass a lookup state, which checks the address and reads the two 8-byte
// rows the access can touch, then a merge state, which merges the bytes and
// writes the rows back for an accepted write. An 8-byte access runs as two
// such 4-byte parts. The next item is taken in the cycle its predecessor
// finishes; one reaching an idle block is taken in the idle state first.
// The store sits in two banks of 8-byte rows (even and odd rows), each with
// a registered read, which is why each part needs a lookup state. A clear
// item, and reset itself, walk both banks one row pair per cycle over all
// 2^(STORE_ADDR_BITS-4) pairs (4096 at the default); a clear item holds on
// its last row until the result slot frees. No item is accepted during the
// walk; the reset walk gives no result. Every item gives exactly one result,
// held in an output register so the next item can proceed while it waits.
`include "assert_macros.svh"

module big_endian_mirrored_ram_top #(
	parameter int STORE_ADDR_BITS = bemr_pkg::STORE_ADDR_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input items
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  command,
	input  logic [1:0]                  size_code,
	input  logic [bemr_pkg::ADDR_W-1:0] address,
	input  logic [bemr_pkg::DATA_W-1:0] write_data,
	// result items
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bemr_pkg::DATA_W-1:0] read_data,
	output logic [1:0]                  status,
	// configuration writes
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [bemr_pkg::BASE_W-1:0] cfg_data
);

	localparam int IDX_BITS = STORE_ADDR_BITS - 4;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CLR  = 2'd1;
	localparam logic [1:0] ST_LOOK = 2'd2;
	localparam logic [1:0] ST_MOD  = 2'd3;

	// control state
	logic [1:0]          state_q;
	logic                clr_cmd_q;
	logic [IDX_BITS-1:0] clr_q;
	logic                part_q;
	logic                out_valid_q;
	logic [bemr_pkg::BASE_W-1:0] dbase_q;
	logic [bemr_pkg::BASE_W-1:0] mbase_q;

	// item and per-part payload
	logic [1:0]                  cmd_q;
	logic [1:0]                  size_q;
	logic [bemr_pkg::ADDR_W-1:0] addr_q;
	logic [bemr_pkg::DATA_W-1:0] wdata_q;
	logic                        ok_q;
	logic [2:0]                  byte_q;
	logic                        par_q;
	logic [IDX_BITS-1:0]         eidx_q;
	logic [IDX_BITS-1:0]         oidx_q;
	logic                        hi_ok_q;
	logic [bemr_pkg::HALF_W-1:0] hi_val_q;
	logic [bemr_pkg::DATA_W-1:0] res_data_q;
	logic [1:0]                  res_status_q;

	logic                        accept;
	logic                        is_rw;
	logic                        two_part;
	logic                        last_part;
	logic [2:0]                  nbytes;
	logic                        out_free;
	logic                        mod_adv;
	logic                        clr_last;
	logic                        clr_adv;
	logic                        res_load;
	logic                        loc_ok;
	logic [STORE_ADDR_BITS-1:0]  loc_off;
	logic [IDX_BITS-1:0]         row_half;
	logic [IDX_BITS-1:0]         eidx;
	logic [bemr_pkg::ROW_W-1:0]  erow;
	logic [bemr_pkg::ROW_W-1:0]  orow;
	logic [bemr_pkg::WIN_W-1:0]  window;
	logic [bemr_pkg::WIN_W-1:0]  wnew;
	logic [bemr_pkg::HALF_W-1:0] wval;
	logic [bemr_pkg::HALF_W-1:0] rval;
	logic [bemr_pkg::HALF_W-1:0] part_val;
	logic                        mod_we;
	logic                        bank_re;
	logic                        bank_we;
	logic [IDX_BITS-1:0]         e_widx;
	logic [IDX_BITS-1:0]         o_widx;
	logic [bemr_pkg::ROW_W-1:0]  e_wdata;
	logic [bemr_pkg::ROW_W-1:0]  o_wdata;
	logic [bemr_pkg::DATA_W-1:0] res_data_d;
	logic [1:0]                  res_status_d;

	// configuration: always ready, block is idle by contract
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbase_q <= bemr_pkg::DIRECT_BASE_RST;
			mbase_q <= bemr_pkg::MIRROR_BASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bemr_pkg::CFG_DIRECT: dbase_q <= cfg_data;
				bemr_pkg::CFG_MIRROR: mbase_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item decode
	assign is_rw     = (cmd_q == bemr_pkg::CMD_READ) || (cmd_q == bemr_pkg::CMD_WRITE);
	assign two_part  = is_rw && (size_q == bemr_pkg::SIZE_8);
	assign last_part = !two_part || part_q;
	assign nbytes    = (size_q == bemr_pkg::SIZE_8) ? 3'd4 : (3'd1 << size_q);

	// handshake: take the next item when idle, or when the last part retires into a free slot
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == ST_IDLE) ||
		(state_q == ST_MOD && last_part && out_free));
	assign accept   = in_valid && !in_stall;

	assign mod_adv  = (state_q == ST_MOD) && (!last_part || out_free);
	assign clr_last = (clr_q == '1);
	// a clear item holds on its last row until the result slot frees
	assign clr_adv  = (state_q == ST_CLR) && (!clr_last || !clr_cmd_q || out_free);
	assign res_load = (state_q == ST_MOD && last_part && out_free) ||
		(state_q == ST_CLR && clr_last && clr_cmd_q && out_free);

	// address check for the current part
	bemr_locate #(
		.STORE_ADDR_BITS(STORE_ADDR_BITS)
	) u_locate (
		.address    (addr_q),
		.part       (part_q),
		.nbytes     (nbytes),
		.direct_base(dbase_q),
		.mirror_base(mbase_q),
		.ok         (loc_ok),
		.off        (loc_off)
	);

	// row r and row r+1 always sit in opposite banks
	assign row_half = loc_off[STORE_ADDR_BITS-1:4];
	assign eidx     = loc_off[3] ? row_half + IDX_BITS'(1) : row_half;

	// merge window: first row of the access on top
	assign window   = par_q ? {orow, erow} : {erow, orow};
	assign wval     = (two_part && !part_q) ? wdata_q[63:32] : wdata_q[31:0];
	assign part_val = ok_q ? rval : '0;

	bemr_lane u_lane (
		.window  (window),
		.byte_off(byte_q),
		.nbytes  (nbytes),
		.wval    (wval),
		.rval    (rval),
		.wnew    (wnew)
	);

	// bank ports: clear walk writes zero rows, otherwise write back the merge
	assign mod_we  = mod_adv && (cmd_q == bemr_pkg::CMD_WRITE) && ok_q;
	assign bank_re = (state_q == ST_LOOK);
	assign bank_we = (state_q == ST_CLR) || mod_we;
	assign e_widx  = (state_q == ST_CLR) ? clr_q : eidx_q;
	assign o_widx  = (state_q == ST_CLR) ? clr_q : oidx_q;
	assign e_wdata = (state_q == ST_CLR) ? '0 : (par_q ? wnew[63:0] : wnew[127:64]);
	assign o_wdata = (state_q == ST_CLR) ? '0 : (par_q ? wnew[127:64] : wnew[63:0]);

	bemr_bank #(
		.IDX_BITS(IDX_BITS)
	) u_bank_even (
		.clk  (clk),
		.re   (bank_re),
		.ridx (eidx),
		.rdata(erow),
		.we   (bank_we),
		.widx (e_widx),
		.wdata(e_wdata)
	);

	bemr_bank #(
		.IDX_BITS(IDX_BITS)
	) u_bank_odd (
		.clk  (clk),
		.re   (bank_re),
		.ridx (row_half),
		.rdata(orow),
		.we   (bank_we),
		.widx (o_widx),
		.wdata(o_wdata)
	);

	// result of the retiring item
	always_comb begin
		res_data_d   = '0;
		res_status_d = bemr_pkg::STATUS_REJ;
		if (state_q == ST_CLR) begin
			res_status_d = bemr_pkg::STATUS_DONE;
		end else if (!is_rw) begin
			res_status_d = bemr_pkg::STATUS_REJ;
		end else if (two_part) begin
			if (cmd_q == bemr_pkg::CMD_READ) begin
				res_data_d = {hi_val_q, part_val};
			end
			if (hi_ok_q && ok_q) begin
				res_status_d = bemr_pkg::STATUS_DONE;
			end else if (hi_ok_q || ok_q) begin
				res_status_d = bemr_pkg::STATUS_HALF;
			end else begin
				res_status_d = bemr_pkg::STATUS_REJ;
			end
		end else begin
			if (cmd_q == bemr_pkg::CMD_READ) begin
				res_data_d = {{(bemr_pkg::DATA_W-bemr_pkg::HALF_W){1'b0}}, part_val};
			end
			res_status_d = ok_q ? bemr_pkg::STATUS_DONE : bemr_pkg::STATUS_REJ;
		end
	end

	// sequencer; reset starts with a silent clear walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_cmd_q <= 1'b0;
			clr_q     <= '0;
			part_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						part_q    <= 1'b0;
						clr_cmd_q <= 1'b1;
						state_q   <= (command == bemr_pkg::CMD_CLEAR) ? ST_CLR : ST_LOOK;
					end
				end
				ST_CLR: begin
					if (clr_adv) begin
						clr_q <= clr_q + IDX_BITS'(1);
						if (clr_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_LOOK: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (mod_adv) begin
						if (!last_part) begin
							// advance to the low half
							part_q  <= 1'b1;
							state_q <= ST_LOOK;
						end else if (accept) begin
							part_q    <= 1'b0;
							clr_cmd_q <= 1'b1;
							state_q   <= (command == bemr_pkg::CMD_CLEAR) ? ST_CLR : ST_LOOK;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item and part payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command;
			size_q  <= size_code;
			addr_q  <= address;
			wdata_q <= write_data;
		end
		if (state_q == ST_LOOK) begin
			ok_q   <= loc_ok && is_rw;
			byte_q <= loc_off[2:0];
			par_q  <= loc_off[3];
			eidx_q <= eidx;
			oidx_q <= row_half;
		end
		if (mod_adv && !last_part) begin
			hi_ok_q  <= ok_q;
			hi_val_q <= part_val;
		end
		if (res_load) begin
			res_data_q   <= res_data_d;
			res_status_q <= res_status_d;
		end
	end

	// result register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = res_data_q;
	assign status    = res_status_q;

	`BEMR_ASSERT_IMPL(a_accept_state, clk, arst_n, accept, state_q == ST_IDLE || state_q == ST_MOD, "item taken mid-access")
	`BEMR_ASSERT_NEXT(a_look_to_mod, clk, arst_n, state_q == ST_LOOK, state_q == ST_MOD, "lookup not followed by merge")
	`BEMR_ASSERT_IMPL(a_load_free, clk, arst_n, res_load, !out_valid_q || !out_stall, "result overwritten")
	`BEMR_ASSERT_IMPL(a_port_excl, clk, arst_n, bank_re, !bank_we, "bank read and write collide")

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for big_endian_mirrored_ram_top: drives read, write and clear items
// through both address windows, predicts each result and checks it field by field.
// Depends on bemr_pkg and the block's RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Codes the package leaves unnamed
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] SIZE_1 = 2'd0;
	localparam logic [1:0] SIZE_2 = 2'd1;
	localparam logic [1:0] SIZE_4 = 2'd2;

	localparam int STORE_BYTES = 1 << bemr_pkg::STORE_ADDR_BITS_DEF;
	localparam logic [63:0] STORE_SPAN = 64'd1 << bemr_pkg::STORE_ADDR_BITS_DEF;
	localparam logic [63:0] ADDR_TOP = 64'h0000_0000_FFFF_FFFF;
	// One row pair per cycle during a clear walk, unless a clear item waits on its last row
	localparam int unsigned CLEAR_WALK_CYCLES = 1 << (bemr_pkg::STORE_ADDR_BITS_DEF - 4);
	localparam int unsigned CONFIG_PAUSE = CLEAR_WALK_CYCLES + 16;
	localparam int unsigned END_SETTLE = 32;
	localparam int unsigned LONG_HOLD_CYCLES = 300;
	localparam int unsigned ITEMS_PER_LAYOUT = 205;
	localparam int unsigned BACKPRESSURE_ITEMS = 80;
	localparam int unsigned RECENT_DEPTH = 48;

	typedef struct packed {
		logic [bemr_pkg::DATA_W-1:0] read_data;
		logic [1:0]                  status;
	} ram_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [1:0]                    command;
	logic [1:0]                    size_code;
	logic [bemr_pkg::ADDR_W-1:0]   address;
	logic [bemr_pkg::DATA_W-1:0]   write_data;
	logic                          out_valid;
	logic                          out_stall;
	logic [bemr_pkg::DATA_W-1:0]   read_data;
	logic [1:0]                    status;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic                          cfg_index;
	logic [bemr_pkg::BASE_W-1:0]   cfg_data;

	// Shadow of the block: byte image plus the two window bases
	logic [7:0]                    ram_image [STORE_BYTES];
	logic [bemr_pkg::BASE_W-1:0]   direct_base;
	logic [bemr_pkg::BASE_W-1:0]   mirror_base;

	ram_result_t                   awaited_results[$];
	logic [bemr_pkg::ADDR_W-1:0]   recent_writes[$];
	int unsigned                   error_count;
	bit                            idle_enabled = 1'b1;
	bit                            long_hold_req;

	big_endian_mirrored_ram_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.size_code  (size_code),
		.address    (address),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.status     (status),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#40_000_000;
		$display("tb: FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- shadow model

	function automatic void wipe_image();
		foreach (ram_image[i]) ram_image[i] = 8'h00;
	endfunction

	// Resolve an access of nbytes to a store offset; direct window first, then mirror.
	// The first byte picks the window, and running off its end rejects the access.
	function automatic bit map_to_store(input logic [63:0] addr, input int unsigned nbytes,
			output logic [63:0] offset);
		logic [63:0] rel;
		offset = '0;
		// Last byte past the 32-bit space, register window included
		if (addr > ADDR_TOP - nbytes)
			return 1'b0;
		if (addr >= {32'b0, direct_base}) begin
			rel = addr - {32'b0, direct_base};
			if (rel < STORE_SPAN) begin
				offset = rel;
				return rel + nbytes <= STORE_SPAN;
			end
		end
		if (addr >= {32'b0, mirror_base}) begin
			rel = addr - {32'b0, mirror_base};
			if (rel < STORE_SPAN) begin
				offset = rel;
				return rel + nbytes <= STORE_SPAN;
			end
		end
		return 1'b0;
	endfunction

	function automatic bit load_bytes(input logic [63:0] addr, input int unsigned nbytes,
			output logic [63:0] value);
		logic [63:0] offset;
		int unsigned i;
		value = '0;
		if (!map_to_store(addr, nbytes, offset))
			return 1'b0;
		for (i = 0; i < nbytes; i++)
			value = (value << 8) | ram_image[offset[bemr_pkg::STORE_ADDR_BITS_DEF-1:0] + i];
		return 1'b1;
	endfunction

	function automatic bit store_bytes(input logic [63:0] addr, input int unsigned nbytes,
			input logic [63:0] value);
		logic [63:0] offset;
		int unsigned i;
		if (!map_to_store(addr, nbytes, offset))
			return 1'b0;
		// Lowest address takes the most significant byte
		for (i = 0; i < nbytes; i++)
			ram_image[offset[bemr_pkg::STORE_ADDR_BITS_DEF-1:0] + i] =
				8'(value >> (8 * (nbytes - 1 - i)));
		return 1'b1;
	endfunction

	// Apply one item to the shadow and return the result it must produce
	function automatic ram_result_t apply_access(input logic [1:0] cmd, input logic [1:0] sz,
			input logic [63:0] addr, input logic [63:0] data);
		ram_result_t res;
		int unsigned nbytes;
		logic [63:0] word;
		logic [63:0] hi_word;
		logic [63:0] lo_word;
		bit hi_ok;
		bit lo_ok;
		res.read_data = '0;
		res.status = bemr_pkg::STATUS_REJ;
		nbytes = 1 << sz;
		case (cmd)
		bemr_pkg::CMD_CLEAR: begin
			wipe_image();
			res.status = bemr_pkg::STATUS_DONE;
		end
		bemr_pkg::CMD_READ, bemr_pkg::CMD_WRITE: begin
			if (sz != bemr_pkg::SIZE_8) begin
				if (cmd == bemr_pkg::CMD_READ) begin
					hi_ok = load_bytes(addr, nbytes, word);
					res.read_data = word;
				end else
					hi_ok = store_bytes(addr, nbytes, data & ((64'd1 << (8 * nbytes)) - 1));
				res.status = hi_ok ? bemr_pkg::STATUS_DONE : bemr_pkg::STATUS_REJ;
			end else begin
				// Eight bytes: two four-byte halves, each checked on its own
				lo_ok = 1'b0;
				lo_word = '0;
				if (cmd == bemr_pkg::CMD_READ) begin
					hi_ok = load_bytes(addr, 4, hi_word);
					if (addr <= ADDR_TOP)
						lo_ok = load_bytes(addr + 4, 4, lo_word);
					res.read_data = {hi_word[31:0], lo_word[31:0]};
				end else begin
					hi_ok = store_bytes(addr, 4, {32'b0, data[63:32]});
					if (addr <= ADDR_TOP)
						lo_ok = store_bytes(addr + 4, 4, {32'b0, data[31:0]});
				end
				if (hi_ok && lo_ok)
					res.status = bemr_pkg::STATUS_DONE;
				else if (hi_ok || lo_ok)
					res.status = bemr_pkg::STATUS_HALF;
				else
					res.status = bemr_pkg::STATUS_REJ;
			end
		end
		default: begin
			// Unused code: nothing moves, rejected
		end
		endcase
		return res;
	endfunction

	// ---------------------------------------------------------------- drivers

	// Most idle stretches are short, a few are long
	function automatic int unsigned idle_length();
		return ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(10, 40);
	endfunction

	// Offer one item, hold it until accepted, then log its expected result
	task automatic send_item(input logic [1:0] cmd, input logic [1:0] sz,
			input logic [63:0] addr, input logic [63:0] data);
		int unsigned gap;
		gap = (idle_enabled && $urandom_range(0, 99) < 35) ? idle_length() : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		size_code <= sz;
		address <= addr;
		write_data <= data;
		do @(posedge clk); while (in_stall);
		awaited_results.push_back(apply_access(cmd, sz, addr, data));
	endtask

	// Drop valid, wait out every pending result, then let the block settle
	task automatic drain_results(input int unsigned settle_cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (settle_cycles) @(posedge clk);
	endtask

	task automatic write_window_base(input logic idx, input logic [bemr_pkg::BASE_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == bemr_pkg::CFG_DIRECT)
			direct_base = value;
		else
			mirror_base = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Aim mostly inside a window, with a share at window edges, space top and far out
	function automatic logic [63:0] pick_address();
		int unsigned r;
		logic [63:0] base;
		r = $urandom_range(0, 99);
		base = $urandom_range(0, 1) ? {32'b0, direct_base} : {32'b0, mirror_base};
		if (r < 55)
			return base + ($urandom_range(0, 1) ? $urandom_range(0, 255)
				: $urandom_range(0, STORE_BYTES - 1));
		if (r < 67)
			return base + STORE_SPAN - $urandom_range(1, 9);
		if (r < 74)
			return base - $urandom_range(1, 8);
		if (r < 82)
			return ADDR_TOP - $urandom_range(0, 12);
		if (r < 92)
			return {32'b0, $urandom()};
		return {$urandom(), $urandom()};
	endfunction

	task automatic send_random_item();
		int unsigned r;
		logic [1:0] cmd;
		logic [1:0] sz;
		logic [63:0] addr;
		logic [63:0] data;
		r = $urandom_range(0, 199);
		sz = 2'($urandom_range(0, 3));
		data = {$urandom(), $urandom()};
		if ($urandom_range(0, 15) == 0)
			data = $urandom_range(0, 1) ? '1 : '0;
		// Clears are rare: each one walks the whole store
		if (r < 2)
			cmd = bemr_pkg::CMD_CLEAR;
		else if (r < 4)
			cmd = CMD_UNUSED;
		else if (r < 95)
			cmd = bemr_pkg::CMD_WRITE;
		else
			cmd = bemr_pkg::CMD_READ;
		if (cmd == bemr_pkg::CMD_READ && recent_writes.size() != 0 &&
				$urandom_range(0, 9) < 7) begin
			// Read back something written lately, now and then shifted or through the other window
			addr = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
			if ($urandom_range(0, 3) == 0)
				addr = addr + $urandom_range(0, 7) - 3;
			if ($urandom_range(0, 3) == 0)
				addr = addr - {32'b0, direct_base} + {32'b0, mirror_base};
		end else
			addr = pick_address();
		if (cmd == bemr_pkg::CMD_WRITE) begin
			recent_writes.push_back(addr);
			if (recent_writes.size() > RECENT_DEPTH)
				void'(recent_writes.pop_front());
		end
		send_item(cmd, sz, addr, data);
	endtask

	// ---------------------------------------------------------------- tests

	// Hand-picked items at the reset window layout
	task automatic test_directed_cases();
		// fresh store reads zero
		send_item(bemr_pkg::CMD_READ,  SIZE_1, 64'h0, 64'h0);
		send_item(bemr_pkg::CMD_WRITE, bemr_pkg::SIZE_8, 64'h10, 64'h0123_4567_89AB_CDEF);
		send_item(bemr_pkg::CMD_READ,  SIZE_1, 64'h10, 64'h0);
		// odd address
		send_item(bemr_pkg::CMD_READ,  SIZE_2, 64'h13, 64'h0);
		send_item(bemr_pkg::CMD_READ,  SIZE_4, 64'h12, 64'h0);
		// same bytes via mirror
		send_item(bemr_pkg::CMD_READ,  bemr_pkg::SIZE_8, 64'h8000_0010, 64'h0);
		// only the low byte lands
		send_item(bemr_pkg::CMD_WRITE, SIZE_1, 64'h20, '1);
		send_item(bemr_pkg::CMD_WRITE, SIZE_2, 64'h8000_0021, 64'hFEDC_BA98_7654_3210);
		send_item(bemr_pkg::CMD_READ,  SIZE_4, 64'h1F, 64'h0);
		// runs off the direct window
		send_item(bemr_pkg::CMD_READ,  SIZE_4, 64'hFFFE, 64'h0);
		// low half has no window
		send_item(bemr_pkg::CMD_WRITE, bemr_pkg::SIZE_8, 64'hFFFC, 64'hAAAA_5555_CCCC_3333);
		send_item(bemr_pkg::CMD_READ,  bemr_pkg::SIZE_8, 64'hFFFC, 64'h0);
		// last word of mirror
		send_item(bemr_pkg::CMD_READ,  bemr_pkg::SIZE_8, 64'h8000_FFF8, 64'h0);
		// between windows
		send_item(bemr_pkg::CMD_READ,  SIZE_2, 64'h4000_0000, 64'h0);
		// register window at top
		send_item(bemr_pkg::CMD_READ,  SIZE_4, 64'hFFFF_FFFC, 64'h0);
		send_item(bemr_pkg::CMD_READ,  SIZE_1, 64'hFFFF_FFFF, 64'h0);
		// far beyond 32 bits
		send_item(bemr_pkg::CMD_WRITE, bemr_pkg::SIZE_8, '1, '1);
		send_item(bemr_pkg::CMD_READ,  bemr_pkg::SIZE_8, 64'h0000_0001_0000_0000, 64'h0);
		send_item(CMD_UNUSED, bemr_pkg::SIZE_8, 64'h10, '1);
		send_item(bemr_pkg::CMD_WRITE, SIZE_4, 64'h7FFF_FFFE, 64'h1234_5678);
		send_item(bemr_pkg::CMD_CLEAR, SIZE_1, 64'h0, 64'h0);
		// cleared
		send_item(bemr_pkg::CMD_READ,  bemr_pkg::SIZE_8, 64'h10, 64'h0);
		send_item(bemr_pkg::CMD_READ,  SIZE_4, 64'hFFFC, 64'h0);
	endtask

	// Random traffic under a series of window layouts, extremes first
	task automatic test_window_layouts();
		logic [bemr_pkg::BASE_W-1:0] d_bases [9];
		logic [bemr_pkg::BASE_W-1:0] m_bases [9];
		int unsigned k;
		// extremes, same base (direct wins), back to back (no fall-through),
		// window across the top of the space, mirror below direct, three random, reset layout
		d_bases = '{32'hFFFF_FFFF, 32'h0001_0000, 32'h1000_0000, 32'hFFFF_8000, 32'h0000_8000,
			32'h0, 32'h0, 32'h0, bemr_pkg::DIRECT_BASE_RST};
		m_bases = '{32'h0000_0000, 32'h0001_0000, 32'h1001_0000, 32'hFFFF_FFFF, 32'h0000_0000,
			32'h0, 32'h0, 32'h0, bemr_pkg::MIRROR_BASE_RST};
		for (k = 5; k < 8; k++) begin
			d_bases[k] = $urandom();
			m_bases[k] = $urandom_range(0, 1) ? d_bases[k] + $urandom_range(0, 32'h2_0000)
				: $urandom();
		end
		for (k = 0; k < 9; k++) begin
			drain_results(CONFIG_PAUSE);
			if (k[0]) begin
				write_window_base(bemr_pkg::CFG_MIRROR, m_bases[k]);
				write_window_base(bemr_pkg::CFG_DIRECT, d_bases[k]);
			end else begin
				write_window_base(bemr_pkg::CFG_DIRECT, d_bases[k]);
				write_window_base(bemr_pkg::CFG_MIRROR, m_bases[k]);
			end
			recent_writes.delete();
			// Every third layout runs back to back with no idling
			idle_enabled = (k % 3 != 1);
			repeat (ITEMS_PER_LAYOUT) send_random_item();
		end
		idle_enabled = 1'b1;
	endtask

	// Results held off for a long stretch while items keep coming, so the block backs up
	task automatic test_result_backpressure();
		idle_enabled = 1'b0;
		long_hold_req = 1'b1;
		repeat (BACKPRESSURE_ITEMS) send_random_item();
		idle_enabled = 1'b1;
	endtask

	// ---------------------------------------------------------------- result side

	// Drive out_stall: random stalls, or one long hold when a test asks for it
	initial begin : result_stall_driver
		int unsigned busy_left;
		busy_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req && busy_left == 0) begin
				busy_left = LONG_HOLD_CYCLES;
				long_hold_req = 1'b0;
			end else if (busy_left == 0 && idle_enabled && $urandom_range(0, 99) < 25)
				busy_left = idle_length();
			if (busy_left != 0) begin
				out_stall <= 1'b1;
				busy_left--;
			end else
				out_stall <= 1'b0;
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : result_checker
		ram_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$error("result with nothing expected: read_data %h status %0d", read_data, status);
				error_count++;
			end else begin
				want = awaited_results.pop_front();
				if (read_data !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data, read_data);
					error_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					error_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : main_sequence
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = bemr_pkg::CMD_READ;
		size_code = SIZE_1;
		address = '0;
		write_data = '0;
		cfg_valid = 1'b0;
		cfg_index = bemr_pkg::CFG_DIRECT;
		cfg_data = '0;
		error_count = 0;
		wipe_image();
		direct_base = bemr_pkg::DIRECT_BASE_RST;
		mirror_base = bemr_pkg::MIRROR_BASE_RST;

		// Hold reset, then release it away from the rising edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_window_layouts();
		test_result_backpressure();

		drain_results(END_SETTLE);
		if (error_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/bemr_pkg.sv
rtl/bemr_bank.sv
rtl/bemr_locate.sv
rtl/bemr_lane.sv
rtl/big_endian_mirrored_ram_top.sv
sim/tb.sv
